// ----- sv/u64dec_pkg.sv -----
// shared types and constants for the 64-bit binary to decimal ascii converter
package u64dec_pkg;

    localparam int IN_W    = 64;  // width of the value field on the input stream
    localparam int OUT_W   = 16;  // result tdata: digit_char and digit_count padded to bytes
    localparam int CHAR_W  = 6;
    localparam int COUNT_W = 5;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

endpackage

// ----- sv/u64dec_dabble.sv -----
// one shift-and-add-3 step of the binary to bcd conversion over all digits
module u64dec_dabble
    import u64dec_pkg::*;
#(
    parameter int NUM_DIGITS = 20
) (
    input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_in,
    input  logic                          bit_in,
    output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_out,
    output logic                          carry_out
);

    logic [NUM_DIGITS*DIGIT_W-1:0] adjusted;

    // digits of five or more get three added so the following shift carries correctly
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_in[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adjusted[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adjusted[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign {carry_out, bcd_out} = {adjusted, bit_in};

endmodule

// ----- sv/uint64_to_decimal_ascii.sv -----
// top level: unsigned binary value in, decimal ascii digit stream out
//
// Each input transaction carries one unsigned value (low VALUE_WIDTH bits used). The block
// answers with one output transaction per decimal digit, most significant first, without
// leading zeros; zero gives a single '0'. tlast marks the final digit, which also carries
// the digit count. Conversion runs one value bit per cycle through a shared shift-and-add-3
// unit over a MAX_DIGITS-digit bcd register, one step per value bit; the digit scan then
// visits each bcd position in turn, whether the position is a skipped leading zero or an
// emitted digit. A value occupies the block from its acceptance until the scan has passed
// the units position; the next value is taken only after that, once the block is idle.
// Back-pressure on the output stretches the scan by the stalled cycles. s_tready is high
// only between values; the final digit may still be waiting in the output register while
// the next value is taken.
// Values with more than MAX_DIGITS digits keep only their lowest MAX_DIGITS digits.
module uint64_to_decimal_ascii
    import u64dec_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [63:0] value
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // [5:0] digit_char, [10:6] digit_count, [15:11] zero
    output logic             m_tlast    // last digit of the value
);

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int BW    = $clog2(VALUE_WIDTH);    // bit counter
    localparam int DW    = $clog2(MAX_DIGITS);     // digit position counter
    localparam int CW    = $clog2(MAX_DIGITS + 1); // emitted digit counter

    // sequencer
    state_t state_reg, state_next;

    // conversion datapath
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic                   ovf_reg, ovf_next;       // digits beyond the bcd register seen
    logic [DW-1:0]          dig_idx_reg, dig_idx_next;
    logic                   started_reg, started_next;
    logic [CW-1:0]          emit_cnt_reg, emit_cnt_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    logic                   out_last_reg, out_last_next;

    // shared shift-and-add-3 unit
    logic [BCD_W-1:0]       step_bcd;
    logic                   step_carry;

    logic                   in_accept;
    logic                   out_free;
    logic [DIGIT_W-1:0]     top_digit;
    logic                   last_pos;
    logic                   do_emit;

    u64dec_dabble #(
        .NUM_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .bcd_in    (bcd_reg),
        .bit_in    (value_reg[VALUE_WIDTH-1]),
        .bcd_out   (step_bcd),
        .carry_out (step_carry)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign last_pos  = (dig_idx_reg == DW'(MAX_DIGITS - 1));
    // a leading zero is skipped unless digits were truncated or it is the units position
    assign do_emit   = started_reg || (top_digit != '0) || last_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        value_next     = value_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        ovf_next       = ovf_reg;
        dig_idx_next   = dig_idx_reg;
        started_next   = started_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    value_next   = s_tdata[VALUE_WIDTH-1:0];
                    bcd_next     = '0;
                    ovf_next     = 1'b0;
                    bit_cnt_next = BW'(VALUE_WIDTH - 1);
                    state_next   = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                value_next   = {value_reg[VALUE_WIDTH-2:0], 1'b0};
                bcd_next     = step_bcd;
                ovf_next     = ovf_reg | step_carry;
                bit_cnt_next = bit_cnt_reg - BW'(1);
                if (bit_cnt_reg == '0) begin
                    dig_idx_next  = '0;
                    started_next  = ovf_reg | step_carry;
                    emit_cnt_next = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (do_emit) begin
                        out_valid_next = 1'b1;
                        out_char_next  = ASCII_ZERO + CHAR_W'(top_digit);
                        out_last_next  = last_pos;
                        out_count_next = last_pos ? COUNT_W'(emit_cnt_reg + CW'(1)) : '0;
                        emit_cnt_next  = emit_cnt_reg + CW'(1);
                        started_next   = 1'b1;
                    end
                    bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dig_idx_next = dig_idx_reg + DW'(1);
                    if (last_pos) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and working registers need no reset
    always_ff @(posedge aclk) begin
        value_reg     <= value_next;
        bcd_reg       <= bcd_next;
        bit_cnt_reg   <= bit_cnt_next;
        ovf_reg       <= ovf_next;
        dig_idx_reg   <= dig_idx_next;
        started_reg   <= started_next;
        emit_cnt_reg  <= emit_cnt_next;
        out_char_reg  <= out_char_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - CHAR_W - COUNT_W){1'b0}}, out_count_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // the final digit carries a count between one and the digit capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[10:6] != '0) &&
                                (m_tdata[10:6] <= COUNT_W'(MAX_DIGITS)))
        else $error("digit count out of range on last digit");

    // other digits carry a zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[10:6] == '0))
        else $error("digit count set on a non-final digit");

    // only decimal digit characters leave the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] >= ASCII_ZERO) && (m_tdata[5:0] <= ASCII_ZERO + CHAR_W'(9)))
        else $error("non-digit character emitted");

    // an accepted value starts conversion at its top bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == ST_CONVERT) && (bit_cnt_reg == BW'(VALUE_WIDTH - 1)))
        else $error("conversion did not start after transaction");

    // scan leaves only after the units position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && !last_pos |=> (state_reg == ST_EMIT))
        else $error("digit scan ended early");
`endif

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the 64-bit binary to decimal ascii converter
`timescale 1ns / 1ps

module tb;
    import u64dec_pkg::*;

    localparam int RANDOM_ITEMS = 290;
    // slowest value: busy time plus every digit held by the longest stall burst plus a sender gap
    localparam int LIMIT_CYCLES = 400000;
    // longer than a value occupies the block at the defaults
    localparam int DRAIN_CYCLES = 120;

    // one expected digit transaction
    typedef struct packed {
        logic [CHAR_W-1:0]  digit_char;
        logic               last;
        logic [COUNT_W-1:0] digit_count;
    } digit_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;   // [63:0] value
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // [5:0] digit_char, [10:6] digit_count, [15:11] zero
    logic             m_tlast;

    logic [IN_W-1:0] values_pending[$];  // values still to be offered
    digit_t          digits_due[$];      // digits predicted but not yet seen
    int              fail_count  = 0;
    int              cycle_count = 0;
    logic            value_taken = 1'b0; // input transaction at the last rising edge
    int              gap_left    = 0;
    int              stall_left  = 0;

    uint64_to_decimal_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // decimal digits of a value, most significant first, count on the last one
    function automatic void predict_decimal(input logic [IN_W-1:0] value);
        logic [DIGIT_W-1:0] rev [20];
        logic [IN_W-1:0]    rest;
        int                 n;
        digit_t             d;
        rest = value;
        n    = 0;
        while (n == 0 || rest != 0) begin
            rev[n] = DIGIT_W'(rest % 10);
            rest   = rest / 10;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            d.digit_char  = ASCII_ZERO + CHAR_W'(rev[k]);
            d.last        = (k == 0);
            d.digit_count = (k == 0) ? COUNT_W'(n) : '0;
            digits_due.push_back(d);
        end
    endfunction

    // stretches with no idling on either side, and none at all near the end
    function automatic bit calm_phase();
        return values_pending.size() < 40 || (values_pending.size() / 50) % 3 == 1;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // monitor: predict on each accepted value, check each accepted digit
    always @(posedge aclk) begin
        digit_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_decimal(s_tdata);
            if (m_tvalid && m_tready) begin
                if (digits_due.size() == 0) begin
                    $error("unexpected digit transaction: char %0d last %0d",
                           m_tdata[CHAR_W-1:0], m_tlast);
                    fail_count++;
                end else begin
                    want = digits_due.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.digit_char) begin
                        $error("digit_char: expected %0d, got %0d",
                               want.digit_char, m_tdata[CHAR_W-1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[CHAR_W +: COUNT_W] !== want.digit_count) begin
                        $error("digit_count: expected %0d, got %0d",
                               want.digit_count, m_tdata[CHAR_W +: COUNT_W]);
                        fail_count++;
                    end
                    if (m_tdata[OUT_W-1:CHAR_W+COUNT_W] !== '0) begin
                        $error("pad: expected 0, got %0d", m_tdata[OUT_W-1:CHAR_W+COUNT_W]);
                        fail_count++;
                    end
                end
            end
        end
        value_taken <= aresetn && s_tvalid && s_tready;
    end

    // driver for the input stream, holds each value until it is taken
    always @(negedge aclk) begin
        logic            nxt_valid;
        logic [IN_W-1:0] nxt_data;
        if (aresetn && (!s_tvalid || value_taken)) begin
            nxt_valid = 1'b0;
            nxt_data  = s_tdata;
            if (gap_left > 0) begin
                gap_left--;
            end else if (!calm_phase() && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 9) - 1;
            end else if (values_pending.size() > 0) begin
                nxt_valid = 1'b1;
                nxt_data  = values_pending.pop_front();
            end
            s_tvalid <= nxt_valid;
            s_tdata  <= nxt_data;
        end
    end

    // back-pressure on the result stream in random bursts
    always @(negedge aclk) begin
        logic rdy;
        if (aresetn) begin
            rdy = 1'b1;
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!calm_phase() && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                rdy = 1'b0;
            end
            m_tready <= rdy;
        end
    end

    initial begin
        logic [IN_W-1:0] pow10 [20];
        logic [IN_W-1:0] v;
        int              k;
        pow10[0] = 64'd1;
        for (int i = 1; i < 20; i++)
            pow10[i] = pow10[i-1] * 10;

        // directed: zero, single digits, digit-count boundaries, bit patterns
        values_pending.push_back(64'd0);
        values_pending.push_back(64'd1);
        values_pending.push_back(64'd9);
        values_pending.push_back(64'd10);
        values_pending.push_back(64'd99);
        values_pending.push_back(64'd100);
        values_pending.push_back(64'd12345);
        values_pending.push_back(pow10[9] - 1);
        values_pending.push_back(pow10[9]);
        values_pending.push_back(64'h0000_0000_FFFF_FFFF);
        values_pending.push_back(64'h0000_0001_0000_0000);
        values_pending.push_back(pow10[18]);
        values_pending.push_back(pow10[19] - 1);
        values_pending.push_back(pow10[19]);
        values_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        values_pending.push_back(64'hFFFF_FFFF_FFFF_FFF6);
        values_pending.push_back(64'h8000_0000_0000_0000);
        values_pending.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        values_pending.push_back(64'h5555_5555_5555_5555);
        values_pending.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        values_pending.push_back(64'd1234567890123456789);

        // random: full width, random bit length, and values around powers of ten
        repeat (RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0, 1: v = {$urandom, $urandom};
                2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                default: begin
                    k = $urandom_range(1, 19);
                    v = pow10[k] + 64'($urandom_range(0, 6)) - 64'd3;
                end
            endcase
            values_pending.push_back(v);
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (values_pending.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (digits_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/u64dec_pkg.sv
sv/u64dec_dabble.sv
sv/uint64_to_decimal_ascii.sv
tb/tb.sv
